// ===== rtl/hsvwc_pkg.sv =====
// ---------------------------------------------------------------------------
// hsvwc_pkg: shared types and constants for the HSV window classifier
// Beat formats, register indexes, labels, controller states and the
// window test used by the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package hsvwc_pkg;

  localparam int CHAN_W  = 8;
  localparam int COORD_W = 10;
  localparam int SUM_W   = 30;
  localparam int CNT_W   = 21;
  localparam int REG_W   = 24;
  localparam int IDX_W   = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int COUNT_LIMIT    = 1048576;

  // one quotient bit per division step; the mean of coordinates fits COORD_W
  localparam int DIV_STEPS = COORD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [REG_W-1:0] RED_CENTRES_RST   = 24'h96A5AA;
  localparam logic [REG_W-1:0] RED_MARGINS_RST   = 24'h3C370A;
  localparam logic [REG_W-1:0] GREEN_CENTRES_RST = 24'h64232D;
  localparam logic [REG_W-1:0] GREEN_MARGINS_RST = 24'h000000;

  typedef enum logic [IDX_W-1:0] {
    REG_RED_CENTRES   = 2'd0,
    REG_RED_MARGINS   = 2'd1,
    REG_GREEN_CENTRES = 2'd2,
    REG_GREEN_MARGINS = 2'd3
  } reg_idx_t;

  localparam logic [1:0] LABEL_NONE  = 2'd0;
  localparam logic [1:0] LABEL_RED   = 2'd1;
  localparam logic [1:0] LABEL_GREEN = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0]  hue;
    logic [CHAN_W-1:0]  saturation;
    logic [CHAN_W-1:0]  brightness;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } pix_t;

  typedef struct packed {
    logic [1:0]         label;
    logic               frame_done;
    logic [CNT_W-1:0]   red_count;
    logic               centroid_valid;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
  } res_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_t;

  typedef struct packed {
    logic load;      // accept the input beat
    logic div_step;  // run one quotient bit
  } cmd_t;

  typedef struct packed {
    logic frame_end; // the beat on the input is the frame's last pixel
  } stat_t;

  // open window: c - m < v < c + m, evaluated without wrap
  function automatic logic win_pass(input logic [CHAN_W-1:0] v,
                                    input logic [CHAN_W-1:0] c,
                                    input logic [CHAN_W-1:0] m);
    logic [CHAN_W:0] vm;
    logic [CHAN_W:0] cm;
    vm = {1'b0, v} + {1'b0, m};
    cm = {1'b0, c} + {1'b0, m};
    return (vm > {1'b0, c}) && ({1'b0, v} < cm);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hsvwc_ctrl.sv =====
// ---------------------------------------------------------------------------
// hsvwc_ctrl: sequencing for the HSV window classifier
// Handles the input and output handshakes and counts the division steps
// that close each frame.
// ---------------------------------------------------------------------------
`default_nettype none

module hsvwc_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire               out_stall,
  input  hsvwc_pkg::stat_t  stat,
  output hsvwc_pkg::cmd_t   cmd
);
  import hsvwc_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              last_step;

  // output register is empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load && stat.frame_end) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (last_step) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !out_free;
        cmd.load = in_valid && out_free;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (cmd.load) step_nxt = '0;
    else if (cmd.div_step) step_nxt = step_r + STEP_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load && !stat.frame_end) out_valid_nxt = 1'b1;
    if (cmd.div_step && last_step) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/hsvwc_dp.sv =====
// ---------------------------------------------------------------------------
// hsvwc_dp: datapath of the HSV window classifier
// Window registers, pixel classification, red accumulators and a
// restoring divider for the column and row means.
// ---------------------------------------------------------------------------
`default_nettype none

module hsvwc_dp #(
  parameter int MAX_WIDTH  = hsvwc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hsvwc_pkg::DEF_MAX_HEIGHT
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  hsvwc_pkg::pix_t              in_data,
  input  wire                          cfg_we,
  input  wire [hsvwc_pkg::IDX_W-1:0]   cfg_index,
  input  wire [hsvwc_pkg::REG_W-1:0]   cfg_data,
  input  hsvwc_pkg::cmd_t              cmd,
  output hsvwc_pkg::stat_t             stat,
  output hsvwc_pkg::res_t              out_data
);
  import hsvwc_pkg::*;

  localparam longint FRAME_PIXELS = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam longint CAP_L = (FRAME_PIXELS < longint'(COUNT_LIMIT)) ? FRAME_PIXELS
                                                                    : longint'(COUNT_LIMIT);
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_L);
  localparam int PAD_W = SUM_W - CNT_W;

  logic [REG_W-1:0] red_c_r, red_m_r, grn_c_r, grn_m_r;

  logic [SUM_W-1:0] sum_col_r, sum_col_nxt;
  logic [SUM_W-1:0] sum_row_r, sum_row_nxt;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;

  logic [1:0]         label_r;
  logic               frame_done_r;
  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   rem_x_r, rem_y_r, dsh_r;
  logic [COORD_W-1:0] q_x_r, q_y_r;

  logic       red_hue, red_all, grn_all;
  logic [1:0] label;
  logic       accum;
  logic       ge_x, ge_y;
  logic       cent_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_c_r <= RED_CENTRES_RST;
      red_m_r <= RED_MARGINS_RST;
      grn_c_r <= GREEN_CENTRES_RST;
      grn_m_r <= GREEN_MARGINS_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RED_CENTRES:   red_c_r <= cfg_data;
        REG_RED_MARGINS:   red_m_r <= cfg_data;
        REG_GREEN_CENTRES: grn_c_r <= cfg_data;
        REG_GREEN_MARGINS: grn_m_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // green is only looked at when the red hue test fails
  always_comb begin
    red_hue = win_pass(in_data.hue, red_c_r[7:0], red_m_r[7:0]);
    red_all = red_hue
           && win_pass(in_data.saturation, red_c_r[15:8], red_m_r[15:8])
           && win_pass(in_data.brightness, red_c_r[23:16], red_m_r[23:16]);
    grn_all = win_pass(in_data.hue, grn_c_r[7:0], grn_m_r[7:0])
           && win_pass(in_data.saturation, grn_c_r[15:8], grn_m_r[15:8])
           && win_pass(in_data.brightness, grn_c_r[23:16], grn_m_r[23:16]);
    if (red_hue) label = red_all ? LABEL_RED : LABEL_NONE;
    else         label = grn_all ? LABEL_GREEN : LABEL_NONE;
  end

  assign accum = (label == LABEL_RED) && (hit_cnt_r < COUNT_CAP);

  always_comb begin
    sum_col_nxt = sum_col_r;
    sum_row_nxt = sum_row_r;
    hit_cnt_nxt = hit_cnt_r;
    if (accum) begin
      sum_col_nxt = sum_col_r + SUM_W'(in_data.column);
      sum_row_nxt = sum_row_r + SUM_W'(in_data.row);
      hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_col_r <= '0;
      sum_row_r <= '0;
      hit_cnt_r <= '0;
    end else if (cmd.load) begin
      if (in_data.frame_end) begin
        sum_col_r <= '0;
        sum_row_r <= '0;
        hit_cnt_r <= '0;
      end else begin
        sum_col_r <= sum_col_nxt;
        sum_row_r <= sum_row_nxt;
        hit_cnt_r <= hit_cnt_nxt;
      end
    end
  end

  assign ge_x = (rem_x_r >= dsh_r);
  assign ge_y = (rem_y_r >= dsh_r);

  // divisor starts aligned to the top quotient bit and walks down one bit a step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      label_r      <= label;
      frame_done_r <= in_data.frame_end;
      if (in_data.frame_end) begin
        count_r <= hit_cnt_nxt;
        rem_x_r <= sum_col_nxt;
        rem_y_r <= sum_row_nxt;
        dsh_r   <= {hit_cnt_nxt, PAD_W'(0)};
        q_x_r   <= '0;
        q_y_r   <= '0;
      end
    end else if (cmd.div_step) begin
      if (ge_x) rem_x_r <= rem_x_r - dsh_r;
      if (ge_y) rem_y_r <= rem_y_r - dsh_r;
      q_x_r <= {q_x_r[COORD_W-2:0], ge_x};
      q_y_r <= {q_y_r[COORD_W-2:0], ge_y};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign cent_ok = frame_done_r && (count_r != '0);

  always_comb begin
    out_data.label          = label_r;
    out_data.frame_done     = frame_done_r;
    out_data.red_count      = frame_done_r ? count_r : '0;
    out_data.centroid_valid = cent_ok;
    out_data.centroid_x     = cent_ok ? q_x_r : '0;
    out_data.centroid_y     = cent_ok ? q_y_r : '0;
  end

  assign stat.frame_end = in_data.frame_end;

endmodule

`default_nettype wire

// ===== rtl/hsv_window_classify_centroid.sv =====
// ---------------------------------------------------------------------------
// hsv_window_classify_centroid: HSV color window classifier, red centroid
// Labels each pixel red, green or none and closes each frame with the
// red pixel count and its truncated mean column and row.
// ---------------------------------------------------------------------------
// A pixel that does not end a frame is taken and its result registered at
// the edge that accepts it, so such pixels stream at one per clock as long as
// the result side keeps up. For the pixel marked frame_end the column and row
// means come from a restoring divider, its one divisor shared by both, that
// produces one quotient bit of each mean per cycle, and no pixel is accepted
// until that result sits in the output register. Window registers may be
// written through the cfg port at any cycle; cfg_ready is always high.
`default_nettype none

module hsv_window_classify_centroid #(
  parameter int MAX_WIDTH  = hsvwc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hsvwc_pkg::DEF_MAX_HEIGHT
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  hsvwc_pkg::pix_t              in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output hsvwc_pkg::res_t              out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [hsvwc_pkg::IDX_W-1:0]   cfg_index,
  input  wire [hsvwc_pkg::REG_W-1:0]   cfg_data
);
  import hsvwc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  hsvwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  hsvwc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
